@@ sv/jac_pkg.sv @@
// Shared types and constants for the joystick axis calibrator and mapper.
// Used by jac_calib, jac_div and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package jac_pkg;

  localparam int NUM_AXES      = 4;
  localparam int AXIS_W        = 2;
  localparam int ADC_BITS      = 10;
  localparam int CNT_W         = 16;
  localparam int OUT_W         = 20;
  localparam int PROD_W        = OUT_W - 1;
  localparam int DIV_STEPS     = PROD_W;
  localparam int STEP_W        = $clog2(DIV_STEPS);
  localparam int HALF_SPAN     = 500;
  localparam int SAMPLE_CNT_RST = 200;

  localparam logic [ADC_BITS-1:0] ADC_MAX    = {ADC_BITS{1'b1}};
  localparam logic [ADC_BITS-1:0] ADC_CENTER = {1'b0, {(ADC_BITS-1){1'b1}}};

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_MAP    = 2'd2,
    REQ_NOP    = 2'd3
  } req_t;

  typedef struct packed {
    req_t                req_type;
    logic [AXIS_W-1:0]   axis;
    logic [ADC_BITS-1:0] raw_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] mapped_value;
    logic                    zero_divisor;
    logic                    calib_done;
    logic [ADC_BITS-1:0]     axis_min_out;
    logic [ADC_BITS-1:0]     axis_max_out;
    logic [ADC_BITS-1:0]     axis_center_out;
  } out_item_t;

  typedef struct packed {
    logic                start;
    logic                sample;
    logic [AXIS_W-1:0]   axis;
    logic [ADC_BITS-1:0] raw;
  } calib_cmd_t;

  typedef struct packed {
    logic [ADC_BITS-1:0] min_val;
    logic [ADC_BITS-1:0] max_val;
    logic [ADC_BITS-1:0] center_val;
    logic                done;
  } axis_view_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

@@ sv/jac_calib.sv @@
// Calibration tracker and axis table: running min/max, sample counter,
// sample count register and the per-axis min/max/center store. Uses jac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jac_calib import jac_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  input  wire calib_cmd_t       cmd,
  output axis_view_t            view
);

  logic [CNT_W-1:0]    sample_count_r;
  logic                active_r;
  logic [AXIS_W-1:0]   cal_axis_r;
  logic [ADC_BITS-1:0] run_min_r;
  logic [ADC_BITS-1:0] run_max_r;
  logic [CNT_W-1:0]    taken_r;
  logic [ADC_BITS-1:0] tbl_min_r    [NUM_AXES];
  logic [ADC_BITS-1:0] tbl_max_r    [NUM_AXES];
  logic [ADC_BITS-1:0] tbl_center_r [NUM_AXES];

  logic                fold;
  logic                commit;
  logic [ADC_BITS-1:0] new_min;
  logic [ADC_BITS-1:0] new_max;
  logic [ADC_BITS:0]   new_sum;
  logic [ADC_BITS-1:0] new_center;
  logic [CNT_W-1:0]    taken_inc;
  logic [AXIS_W-1:0]   disp_axis;

  always_comb begin
    fold       = cmd.sample && active_r;
    new_min    = (cmd.raw < run_min_r) ? cmd.raw : run_min_r;
    new_max    = (cmd.raw > run_max_r) ? cmd.raw : run_max_r;
    new_sum    = {1'b0, new_min} + {1'b0, new_max};
    new_center = new_sum[ADC_BITS:1];
    taken_inc  = taken_r + CNT_W'(1);
    commit     = fold && (taken_inc >= sample_count_r);
    disp_axis  = fold ? cal_axis_r : cmd.axis;
    if (commit) begin
      view.min_val    = new_min;
      view.max_val    = new_max;
      view.center_val = new_center;
    end else begin
      view.min_val    = tbl_min_r[disp_axis];
      view.max_val    = tbl_max_r[disp_axis];
      view.center_val = tbl_center_r[disp_axis];
    end
    view.done = commit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= CNT_W'(SAMPLE_CNT_RST);
      active_r       <= 1'b0;
      cal_axis_r     <= '0;
      run_min_r      <= ADC_MAX;
      run_max_r      <= '0;
      taken_r        <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        tbl_min_r[i]    <= '0;
        tbl_max_r[i]    <= ADC_MAX;
        tbl_center_r[i] <= ADC_CENTER;
      end
    end else begin
      if (cfg_we) begin
        sample_count_r <= cfg_wdata;
      end
      if (cmd.start) begin
        active_r   <= 1'b1;
        cal_axis_r <= cmd.axis;
        run_min_r  <= ADC_MAX;
        run_max_r  <= '0;
        taken_r    <= '0;
      end else if (fold) begin
        run_min_r <= new_min;
        run_max_r <= new_max;
        taken_r   <= commit ? '0 : taken_inc;
        if (commit) begin
          active_r                 <= 1'b0;
          tbl_min_r[cal_axis_r]    <= new_min;
          tbl_max_r[cal_axis_r]    <= new_max;
          tbl_center_r[cal_axis_r] <= new_center;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/jac_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle, dividend and
// quotient share one shift register. Uses jac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jac_div import jac_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [PROD_W-1:0]   dividend,
  input  wire logic [ADC_BITS-1:0] divisor,
  output div_status_t              status,
  output logic [PROD_W-1:0]        quotient
);

  logic [PROD_W-1:0]   quo_r;
  logic [ADC_BITS-1:0] rem_r;
  logic [ADC_BITS-1:0] div_r;
  logic [STEP_W-1:0]   step_r;
  logic                busy_r;
  logic                done_r;

  logic [ADC_BITS:0]   trial;
  logic [ADC_BITS:0]   diff;
  logic                fits;

  always_comb begin
    trial = {rem_r, quo_r[PROD_W-1]};
    diff  = trial - {1'b0, div_r};
    fits  = trial >= {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DIV_STEPS - 1);
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[PROD_W-2:0], fits};
      rem_r <= fits ? diff[ADC_BITS-1:0] : trial[ADC_BITS-1:0];
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = quo_r;

endmodule

`default_nettype wire

@@ sv/joystick_axis_calibrate_and_map.sv @@
// Top level of the joystick axis calibrator and mapper: request sequencer,
// mapping setup and output register. Uses jac_pkg, jac_calib and jac_div.
//
// One request is worked on at a time, and each gives exactly one result.
// For start, calibration sample and no-operation requests the request is
// registered and handled in the lookup state, and its result is held in the
// finish state until the output register can take it. A map request with a
// nonzero span also passes through the divide state, where the bit-serial
// divider retires one of the 19 quotient bits per cycle. A zero span skips
// the divider and takes the same path as a start request. The next request
// is accepted as soon as the previous result sits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module joystick_axis_calibrate_and_map import jac_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOK = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  in_item_t    req_r;
  out_item_t   res_r, res_nxt;
  out_item_t   out_data_r, out_data_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        neg_r, neg_nxt;
  logic        lower_r, lower_nxt;

  calib_cmd_t  cmd;
  axis_view_t  view;
  div_status_t div_status;
  logic [PROD_W-1:0] quotient;

  logic                      lower;
  logic signed [ADC_BITS:0]  num;
  logic [ADC_BITS-1:0]       den;
  logic [ADC_BITS:0]         num_abs;
  logic [ADC_BITS-1:0]       mag;
  logic [PROD_W-1:0]         prod;
  logic                      div_start;
  logic signed [OUT_W-1:0]   q_signed;
  logic signed [OUT_W-1:0]   offset;

  assign cmd.start  = (state_r == ST_LOOK) && (req_r.req_type == REQ_START);
  assign cmd.sample = (state_r == ST_LOOK) && (req_r.req_type == REQ_SAMPLE);
  assign cmd.axis   = req_r.axis;
  assign cmd.raw    = req_r.raw_sample;

  jac_calib u_calib (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .view      (view)
  );

  always_comb begin
    lower = req_r.raw_sample < view.center_val;
    if (lower) begin
      num = signed'({1'b0, req_r.raw_sample}) - signed'({1'b0, view.min_val});
      den = view.center_val - view.min_val;
    end else begin
      num = signed'({1'b0, req_r.raw_sample}) - signed'({1'b0, view.center_val});
      den = view.max_val - view.center_val;
    end
    num_abs = num[ADC_BITS] ? (~num + (ADC_BITS+1)'(1)) : num;
    mag     = num_abs[ADC_BITS-1:0];
    prod    = PROD_W'(mag) * PROD_W'(HALF_SPAN);
  end

  jac_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod),
    .divisor  (den),
    .status   (div_status),
    .quotient (quotient)
  );

  always_comb begin
    q_signed = neg_r ? -signed'({1'b0, quotient}) : signed'({1'b0, quotient});
    offset   = lower_r ? OUT_W'(-HALF_SPAN) : '0;
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    res_nxt       = res_r;
    neg_nxt       = neg_r;
    lower_nxt     = lower_r;
    div_start     = 1'b0;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        res_nxt.mapped_value    = '0;
        res_nxt.zero_divisor    = 1'b0;
        res_nxt.calib_done      = view.done;
        res_nxt.axis_min_out    = view.min_val;
        res_nxt.axis_max_out    = view.max_val;
        res_nxt.axis_center_out = view.center_val;
        neg_nxt                 = num[ADC_BITS];
        lower_nxt               = lower;
        state_nxt               = ST_FIN;
        if (req_r.req_type == REQ_MAP) begin
          if (den == '0) begin
            res_nxt.zero_divisor = 1'b1;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_status.done) begin
          res_nxt.mapped_value = q_signed + offset;
          state_nxt            = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    res_r      <= res_nxt;
    neg_r      <= neg_nxt;
    lower_r    <= lower_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_status.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  a_div_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_status.busy |-> (state_r == ST_DIV))
    else $error("divider busy outside the divide state");

  a_zero_forces_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.zero_divisor && (out_data_r.mapped_value != '0)))
    else $error("zero span gave a nonzero mapped value");

  a_done_not_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.calib_done && out_data_r.zero_divisor))
    else $error("calibration done and zero span raised together");

  a_commit_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.calib_done) |->
      ((out_data_r.axis_min_out <= out_data_r.axis_center_out) &&
       (out_data_r.axis_center_out <= out_data_r.axis_max_out)))
    else $error("committed center lies outside min and max");

endmodule

`default_nettype wire
